// ===== design/vtp_pkg.sv =====
// ---------------------------------------------------------------------------
// Vertex transform and projection package
// Shared widths, register indexes and the sideband that follows each vertex
// through the divider.
// ---------------------------------------------------------------------------
package vtp_pkg;

	localparam int SCREEN_BITS_DEF = 16;

	localparam int COEF_W  = 48;
	localparam int WORLD_W = 32;
	localparam int ORIG_W  = 12;
	localparam int CFG_IDX_W = 3;

	// Divider operand widths: numerator 2*|1000*w| + |z|, denominator 2*|z|.
	localparam int NUM_W = 43;
	localparam int DEN_W = 28;
	localparam int AD_W  = 27;
	localparam int DIV_STAGES = NUM_W;

	// Far limit -1500.0 in Q16.16.
	localparam logic signed [WORLD_W-1:0] FAR_LIMIT = -32'sd98304000;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_Z  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORG_X  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ORG_Y  = 3'd7;

	typedef struct packed {
		logic                      vis;
		logic                      neg_x;
		logic                      neg_y;
		logic [WORLD_W-1:0]        depth;
	} side_t;

endpackage

// ===== design/vtp_div.sv =====
// ---------------------------------------------------------------------------
// Pipelined restoring divider, two lanes
// One quotient bit per stage for both lanes against a shared denominator;
// the sideband rides along. Each stage holds its beat until the next frees.
// ---------------------------------------------------------------------------
module vtp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [vtp_pkg::NUM_W-1:0] in_num_x,
	input  logic [vtp_pkg::NUM_W-1:0] in_num_y,
	input  logic [vtp_pkg::DEN_W-1:0] in_den,
	input  vtp_pkg::side_t            in_side,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [vtp_pkg::NUM_W-1:0] out_quo_x,
	output logic [vtp_pkg::NUM_W-1:0] out_quo_y,
	output vtp_pkg::side_t            out_side
);
	import vtp_pkg::*;

	// Entry 0 is the input; entries 1..DIV_STAGES are registers.
	logic             v_s    [DIV_STAGES+1];
	logic [DEN_W-1:0] rx_s   [DIV_STAGES+1];
	logic [DEN_W-1:0] ry_s   [DIV_STAGES+1];
	logic [NUM_W-1:0] nx_s   [DIV_STAGES+1];
	logic [NUM_W-1:0] ny_s   [DIV_STAGES+1];
	logic [DEN_W-1:0] d_s    [DIV_STAGES+1];
	side_t            side_s [DIV_STAGES+1];
	logic             en     [DIV_STAGES+1];

	assign v_s[0]    = in_valid;
	assign rx_s[0]   = '0;
	assign ry_s[0]   = '0;
	assign nx_s[0]   = in_num_x;
	assign ny_s[0]   = in_num_y;
	assign d_s[0]    = in_den;
	assign side_s[0] = in_side;
	assign en[0]     = 1'b0;

	assign in_ready = en[1];

	genvar k;
	generate
		for (k = 1; k <= DIV_STAGES; k++) begin : g_stage
			logic [DEN_W:0] tx, ty;
			logic           gx, gy;

			if (k == DIV_STAGES) begin : g_last
				assign en[k] = !v_s[k] || out_ready;
			end else begin : g_mid
				assign en[k] = !v_s[k] || en[k+1];
			end

			assign tx = {rx_s[k-1], nx_s[k-1][NUM_W-1]};
			assign ty = {ry_s[k-1], ny_s[k-1][NUM_W-1]};
			assign gx = tx >= {1'b0, d_s[k-1]};
			assign gy = ty >= {1'b0, d_s[k-1]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					rx_s[k]   <= gx ? DEN_W'(tx - {1'b0, d_s[k-1]}) : DEN_W'(tx);
					ry_s[k]   <= gy ? DEN_W'(ty - {1'b0, d_s[k-1]}) : DEN_W'(ty);
					nx_s[k]   <= {nx_s[k-1][NUM_W-2:0], gx};
					ny_s[k]   <= {ny_s[k-1][NUM_W-2:0], gy};
					d_s[k]    <= d_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	endgenerate

	assign out_valid = v_s[DIV_STAGES];
	assign out_quo_x = nx_s[DIV_STAGES];
	assign out_quo_y = ny_s[DIV_STAGES];
	assign out_side  = side_s[DIV_STAGES];

endmodule

// ===== design/vertex_transform_project_top.sv =====
// ---------------------------------------------------------------------------
// Vertex transform and perspective projection
// Affine 3x3 transform with translation, near/far cull, and projection of
// world x and y by 1000 / world z onto a saturated screen.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata / data                        | tuser
//  s_axis   | in  | local_x, local_y, local_z (32 each) | -
//  m_axis   | out | screen_x, screen_y, world_depth     | visible
//  cfg      | in  | cfg_index (3), cfg_data (48)        | -
//
// One vertex enters every cycle while the output is not stalled; the
// projection divider resolves one bit per stage. Reset clears all valid bits and
// loads the identity matrix. A stall at the output holds only the beats
// that cannot move; bubbles close up, so input is taken while results wait.
// ---------------------------------------------------------------------------
module vertex_transform_project_top #(
	parameter int SCREEN_BITS = vtp_pkg::SCREEN_BITS_DEF,
	parameter int OUT_W = ((2 * SCREEN_BITS + 32 + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [95:0]                   s_axis_tdata,  // local_x, local_y, local_z
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [OUT_W-1:0]              m_axis_tdata,  // screen_x, screen_y, world_depth
	output logic                          m_axis_tuser,  // visible
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vtp_pkg::COEF_W-1:0]    cfg_data
);
	import vtp_pkg::*;

	localparam int VW = NUM_W + 2;
	localparam logic signed [VW-1:0] SHI = (VW'(1) <<< (SCREEN_BITS - 1)) - VW'(1);
	localparam logic signed [VW-1:0] SLO = -SHI - VW'(1);

	// Configuration registers
	logic [COEF_W-1:0]  coef_q [3];
	logic [WORLD_W-1:0] ofs_q  [3];
	logic [ORIG_W-1:0]  org_x_q, org_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= 48'h0000_0000_1000;
			coef_q[1] <= 48'h0000_1000_0000;
			coef_q[2] <= 48'h1000_0000_0000;
			ofs_q[0]  <= '0;
			ofs_q[1]  <= '0;
			ofs_q[2]  <= '0;
			org_x_q   <= '0;
			org_y_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COEF_X: coef_q[0] <= cfg_data;
				REG_COEF_Y: coef_q[1] <= cfg_data;
				REG_COEF_Z: coef_q[2] <= cfg_data;
				REG_OFS_X:  ofs_q[0]  <= cfg_data[WORLD_W-1:0];
				REG_OFS_Y:  ofs_q[1]  <= cfg_data[WORLD_W-1:0];
				REG_OFS_Z:  ofs_q[2]  <= cfg_data[WORLD_W-1:0];
				REG_ORG_X:  org_x_q   <= cfg_data[ORIG_W-1:0];
				REG_ORG_Y:  org_y_q   <= cfg_data[ORIG_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;
	logic en1, en2, en3, en4, en5, en_out;
	logic div_in_ready, div_out_valid;

	assign en_out = !out_v_q || m_axis_tready;
	assign en5 = !v_s5 || div_in_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)    v_s1 <= s_axis_tvalid;
			if (en2)    v_s2 <= v_s1;
			if (en3)    v_s3 <= v_s2;
			if (en4)    v_s4 <= v_s3;
			if (en5)    v_s5 <= v_s4;
			if (en_out) out_v_q <= div_out_valid;
		end
	end

	// Stage 1: nine products, lane l is world axis, j is local axis.
	logic signed [47:0] prod_s1 [3][3];
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int l = 0; l < 3; l++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[l][j] <= $signed(s_axis_tdata[32*j +: 32])
						* $signed(coef_q[j][16*l +: 16]);
				end
			end
		end
	end

	// Stage 2: sum with rounding bias.
	logic signed [49:0] sum_s2 [3];
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int l = 0; l < 3; l++) begin
				sum_s2[l] <= 50'(prod_s1[l][0]) + 50'(prod_s1[l][1])
					+ 50'(prod_s1[l][2]) + 50'sd2048;
			end
		end
	end

	// Stage 3: floor to Q16.16, translate and saturate.
	logic signed [WORLD_W-1:0] wld_s3 [3];
	logic signed [WORLD_W-1:0] wld_s3_d [3];
	always_comb begin
		logic signed [38:0] t;
		for (int l = 0; l < 3; l++) begin
			t = 39'(sum_s2[l] >>> 12) + 39'($signed(ofs_q[l]));
			if (t > 39'sd2147483647)       wld_s3_d[l] = 32'sh7FFF_FFFF;
			else if (t < -39'sd2147483648) wld_s3_d[l] = 32'sh8000_0000;
			else                            wld_s3_d[l] = t[31:0];
		end
	end
	always_ff @(posedge clk) begin
		if (en3) begin
			for (int l = 0; l < 3; l++) wld_s3[l] <= wld_s3_d[l];
		end
	end

	// Stage 4: scale x and y by 1000, cull test on z.
	logic signed [41:0] num_x_s4, num_y_s4;
	logic signed [WORLD_W-1:0] z_s4;
	logic vis_s4;
	always_ff @(posedge clk) begin
		if (en4) begin
			num_x_s4 <= 42'(wld_s3[0]) * 42'sd1000;
			num_y_s4 <= 42'(wld_s3[1]) * 42'sd1000;
			z_s4     <= wld_s3[2];
			vis_s4   <= wld_s3[2][WORLD_W-1] && (wld_s3[2] >= FAR_LIMIT);
		end
	end

	// Stage 5: magnitudes; round half away via (2|n| + |d|) / (2|d|).
	logic [NUM_W-1:0] nx_s5, ny_s5;
	logic [DEN_W-1:0] den_s5;
	side_t            side_s5;
	logic [40:0]      ax, ay;
	logic [AD_W-1:0]  az;
	logic [WORLD_W-1:0] zabs;
	assign ax = num_x_s4[41] ? 41'(-num_x_s4) : num_x_s4[40:0];
	assign ay = num_y_s4[41] ? 41'(-num_y_s4) : num_y_s4[40:0];
	assign zabs = z_s4[WORLD_W-1] ? WORLD_W'(-z_s4) : z_s4;
	assign az = zabs[AD_W-1:0];

	always_ff @(posedge clk) begin
		if (en5) begin
			nx_s5 <= {1'b0, ax, 1'b0} + NUM_W'(az);
			ny_s5 <= {1'b0, ay, 1'b0} + NUM_W'(az);
			den_s5 <= {az, 1'b0};
			side_s5.vis   <= vis_s4;
			side_s5.neg_x <= num_x_s4[41] ^ z_s4[WORLD_W-1];
			side_s5.neg_y <= num_y_s4[41] ^ z_s4[WORLD_W-1];
			side_s5.depth <= z_s4;
		end
	end

	logic [NUM_W-1:0] qx, qy;
	side_t            div_side;

	vtp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_num_x  (nx_s5),
		.in_num_y  (ny_s5),
		.in_den    (den_s5),
		.in_side   (side_s5),
		.out_valid (div_out_valid),
		.out_ready (en_out),
		.out_quo_x (qx),
		.out_quo_y (qy),
		.out_side  (div_side)
	);

	// Output stage: origin offset and screen saturation.
	logic signed [VW-1:0] vx, vy;
	logic [SCREEN_BITS-1:0] sx_d, sy_d;
	logic [SCREEN_BITS-1:0] sx_q, sy_q;
	logic [WORLD_W-1:0]     depth_q;
	logic                   vis_q;

	assign vx = VW'(org_x_q) + (div_side.neg_x ? -VW'(qx) : VW'(qx));
	assign vy = VW'(org_y_q) - (div_side.neg_y ? -VW'(qy) : VW'(qy));

	always_comb begin
		if (!div_side.vis)  sx_d = '0;
		else if (vx > SHI)  sx_d = SHI[SCREEN_BITS-1:0];
		else if (vx < SLO)  sx_d = SLO[SCREEN_BITS-1:0];
		else                sx_d = vx[SCREEN_BITS-1:0];
		if (!div_side.vis)  sy_d = '0;
		else if (vy > SHI)  sy_d = SHI[SCREEN_BITS-1:0];
		else if (vy < SLO)  sy_d = SLO[SCREEN_BITS-1:0];
		else                sy_d = vy[SCREEN_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			sx_q    <= sx_d;
			sy_q    <= sy_d;
			depth_q <= div_side.depth;
			vis_q   <= div_side.vis;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = vis_q;
	assign m_axis_tdata  = OUT_W'({depth_q, sy_q, sx_q});

	// A ready output means every stage can move, so input is never refused.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output ready");

	a_culled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (sx_q == '0 && sy_q == '0))
		else $error("culled vertex with non-zero screen position");

	a_vis_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> depth_q[WORLD_W-1])
		else $error("visible vertex with non-negative depth");

endmodule
